### rtl/core/tdpt_pkg.sv
// Shared types of the trial-division prime test block.
// Holds the controller-to-datapath command and status structs.
// No dependencies.
package tdpt_pkg;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture a new candidate, restart divisor at three
      logic start_div;  // clear remainder, load dividend, clear bit count
      logic step_div;   // one restoring-division bit step
      logic advance;    // move to the next odd divisor
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic negative;   // candidate sign bit set
      logic le_one;     // candidate is zero or one
      logic is_two;     // candidate equals two
      logic is_even;    // candidate low bit clear
      logic square_gt;  // divisor squared exceeds candidate
      logic div_last;   // final bit step of the current division
      logic rem_zero;   // last remainder is zero
   } dp_sts_type;

endpackage

### rtl/core/tdpt_if.sv
// Valid/ready channel interfaces for the prime test block.
// tdpt_req_if carries a candidate word, tdpt_rsp_if a prime flag word.
// No dependencies.
interface tdpt_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic prime_flag;

   modport source (output valid, output prime_flag, input ready);
   modport sink   (input valid, input prime_flag, output ready);
endinterface

### rtl/core/trial_division_prime_test_top.sv
// Top level of the trial-division prime test block.
// Joins the controller and datapath. Depends on tdpt_pkg, tdpt_if,
// tdpt_ctrl and tdpt_datapath.
//
// Usage:
//  - req_chan carries one signed candidate word per valid/ready handshake.
//  - rsp_chan returns one prime_flag word per candidate, in order.
//  - Negative, zero and one give 0; two gives 1; other even values give 0.
//    Odd values are divided by 3, 5, 7, ... while divisor squared does not
//    exceed the value; any zero remainder gives 0, else 1.
//  - Screening decisions reach rsp_chan through the screen and finish
//    states and the result register. Each trial divisor takes a screen,
//    DATA_WIDTH bit steps of the restoring remainder unit and a check, so
//    a full test repeats these for each of the k divisors tried; worst case
//    at 32 bits is about 23170 divisors.
//  - One candidate is in work at a time; req_chan.ready is high only while
//    idle. The result register lets a new word be accepted while the last
//    flag still waits on rsp_chan.
//  - A stalled receiver holds the flag word; a finished test then waits
//    until the register frees up.
//  - Synchronous reset returns to idle and drops any pending result.
module trial_division_prime_test_top #(
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   tdpt_req_if.sink   req_chan,
   tdpt_rsp_if.source rsp_chan
);
   import tdpt_pkg::*;

   dp_cmd_type cmd;   // sequencer commands to the datapath
   dp_sts_type sts;   // datapath flags back to the sequencer

   // Sequencer: handshakes, test flow and result register
   tdpt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .sts      (sts)
   );

   // Datapath: candidate, divisor, running square, remainder unit
   tdpt_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .candidate (req_chan.candidate),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### rtl/core/tdpt_datapath.sv
// Datapath of the prime test: held value, odd trial divisor, running square
// and a bit-serial restoring remainder unit. Depends on tdpt_pkg.
module tdpt_datapath #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic signed [DATA_WIDTH-1:0] candidate,
   input  tdpt_pkg::dp_cmd_type         cmd,
   output tdpt_pkg::dp_sts_type         sts
);
   import tdpt_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] held_value_ff, held_value_in;
   logic [DATA_WIDTH-1:0] trial_divisor_ff, trial_divisor_in;
   logic [DATA_WIDTH:0]   square_ff, square_in;
   logic [DATA_WIDTH-1:0] partial_remainder_ff, partial_remainder_in;
   logic [DATA_WIDTH-1:0] dividend_ff, dividend_in;
   logic [CNT_W-1:0]      bit_count_ff, bit_count_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;

   // Restoring step: shift in next dividend bit, subtract when it fits
   assign trial = {partial_remainder_ff, dividend_ff[DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, trial_divisor_ff};

   always_comb begin
      held_value_in        = held_value_ff;
      trial_divisor_in     = trial_divisor_ff;
      square_in            = square_ff;
      partial_remainder_in = partial_remainder_ff;
      dividend_in          = dividend_ff;
      bit_count_in         = bit_count_ff;
      if (cmd.load) begin
         held_value_in    = DATA_WIDTH'(candidate);
         trial_divisor_in = DATA_WIDTH'(3);
         square_in        = (DATA_WIDTH+1)'(9);
      end
      if (cmd.start_div) begin
         partial_remainder_in = '0;
         dividend_in          = held_value_ff;
         bit_count_in         = '0;
      end
      if (cmd.step_div) begin
         if (trial >= {1'b0, trial_divisor_ff}) begin
            partial_remainder_in = diff[DATA_WIDTH-1:0];
         end else begin
            partial_remainder_in = trial[DATA_WIDTH-1:0];
         end
         dividend_in  = {dividend_ff[DATA_WIDTH-2:0], 1'b0};
         bit_count_in = bit_count_ff + CNT_W'(1);
      end
      if (cmd.advance) begin
         // (d+2)^2 = d^2 + 4d + 4
         trial_divisor_in = trial_divisor_ff + DATA_WIDTH'(2);
         square_in        = square_ff + {trial_divisor_ff[DATA_WIDTH-2:0], 2'b00}
                            + (DATA_WIDTH+1)'(4);
      end
   end

   always_ff @(posedge clock) begin
      held_value_ff        <= held_value_in;
      trial_divisor_ff     <= trial_divisor_in;
      square_ff            <= square_in;
      partial_remainder_ff <= partial_remainder_in;
      dividend_ff          <= dividend_in;
      bit_count_ff         <= bit_count_in;
   end

   assign sts.negative  = held_value_ff[DATA_WIDTH-1];
   assign sts.le_one    = (held_value_ff[DATA_WIDTH-1:1] == '0);
   assign sts.is_two    = (held_value_ff == DATA_WIDTH'(2));
   assign sts.is_even   = ~held_value_ff[0];
   assign sts.square_gt = (square_ff > {1'b0, held_value_ff});
   assign sts.div_last  = (bit_count_ff == CNT_W'(DATA_WIDTH-1));
   assign sts.rem_zero  = (partial_remainder_ff == '0);

endmodule

### rtl/core/tdpt_ctrl.sv
// Controller of the prime test: one-hot sequencer, input handshake and
// result output register. Depends on tdpt_pkg and tdpt_if.
module tdpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   tdpt_req_if.sink             req_chan,
   tdpt_rsp_if.source           rsp_chan,
   output tdpt_pkg::dp_cmd_type cmd,
   input  tdpt_pkg::dp_sts_type sts
);
   import tdpt_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCREEN = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_CHECK  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      flag_ff, flag_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_prime_ff, rsp_prime_in;
   logic      out_free;

   assign out_free = ~rsp_valid_ff | rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_prime_in = rsp_prime_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCREEN;
            end
         end
         ST_SCREEN: begin
            if (sts.negative || sts.le_one) begin
               flag_in  = 1'b0;
               state_in = ST_FINISH;
            end else if (sts.is_two) begin
               flag_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (sts.is_even) begin
               flag_in  = 1'b0;
               state_in = ST_FINISH;
            end else if (sts.square_gt) begin
               flag_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step_div = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.rem_zero) begin
               flag_in  = 1'b0;
               state_in = ST_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_SCREEN;
            end
         end
         ST_FINISH: begin
            // hold until the output register can take the word
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      flag_ff      <= flag_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.prime_flag = rsp_prime_ff;

`ifndef ASSERT_OFF
   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_SCREEN))
      else $error("accepted word did not start a test");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_chan.ready)
      |=> (state_ff == ST_FINISH && rsp_valid_ff))
      else $error("result overwrote a pending word");

   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && sts.div_last) |=> (state_ff == ST_CHECK))
      else $error("division did not end in check");
`endif

endmodule

### verif/trial_division_prime_test_top_tb.sv
// Testbench for trial_division_prime_test_top: signed candidate words in, prime flags out.
// Depends on tdpt_if (tdpt_req_if, tdpt_rsp_if) and the block's RTL.
module trial_division_prime_test_top_tb;

   localparam int DATA_WIDTH   = 32;
   localparam int RANDOM_WORDS = 100;
   localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
   localparam int HOLD_AT_FLAG = 30;    // flag count that triggers the hold-off
   localparam int DRAIN_CYCLES = 50;

   typedef logic signed [DATA_WIDTH-1:0] cand_type;

   // Scoreboard: holds the predicted prime flags in accept order
   class prime_flag_board;
      typedef struct {
         cand_type candidate;
         bit       flag;
      } verdict_type;

      verdict_type verdicts[$];
      int          mismatches = 0;

      // Predict by trial division with odd divisors up to the square root
      function bit predict_prime(cand_type cand);
         logic [DATA_WIDTH-1:0] n;
         logic [DATA_WIDTH-1:0] d;
         if (cand < 0) return 1'b0;
         n = cand;
         if (n <= 1) return 1'b0;
         if (n == 2) return 1'b1;
         if (!n[0]) return 1'b0;
         d = 3;
         while (d <= n / d) begin
            if (n % d == 0) return 1'b0;
            d = d + 2;
         end
         return 1'b1;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function void note_candidate(cand_type cand);
         verdict_type v;
         v.candidate = cand;
         v.flag      = predict_prime(cand);
         verdicts.push_back(v);
      endfunction

      task check_flag(logic flag);
         verdict_type v;
         if (verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected flag word %b", flag));
            return;
         end
         v = verdicts.pop_front();
         if (flag !== v.flag)
            report_mismatch($sformatf("candidate %0d: flag %b, predicted %b",
                                      v.candidate, flag, v.flag));
      endtask

      function int pending();
         return verdicts.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   tdpt_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_chan();
   tdpt_rsp_if                            rsp_chan();

   prime_flag_board board = new();
   int              flags_taken = 0;

   trial_division_prime_test_top #(.DATA_WIDTH(DATA_WIDTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pick an idle gap: mostly none, often short, now and then long
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   // Offer one candidate word after an optional gap; hold it until accepted.
   // All drives happen at the falling edge, ready is sampled at the rising edge.
   task send_word(cand_type value, int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid     = 1'b0;
         req_chan.candidate = $urandom;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.candidate = value;
      do @(posedge clock); while (!req_chan.ready);
      board.note_candidate(value);
   endtask

   // Hold the sender until every predicted flag has come back
   task wait_for_drain();
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Build a random candidate; keep odd values either small or cheap to reject,
   // since a large prime is tried against every odd divisor up to its square root.
   function cand_type random_candidate();
      int          kind;
      int unsigned p;
      int unsigned q;
      int unsigned m;
      kind = $urandom_range(0, 99);
      if (kind < 30) return $urandom_range(0, 4095);
      if (kind < 45) return $urandom_range(4096, 16383);
      if (kind < 65) return $urandom | 32'h8000_0000;       // negative, any low bits
      if (kind < 80) return $urandom & 32'hffff_fffe;       // even, any sign
      // large odd multiple of a small odd prime: rejected within a few divisors
      case ($urandom_range(0, 4))
         0: p = 3;
         1: p = 5;
         2: p = 7;
         3: p = 11;
         default: p = 13;
      endcase
      q = 32'h7fff_ffff / p;
      m = $urandom_range(0, (q - 1) / 2) * 2 + 1;
      return p * m;
   endfunction

   // Stimulus: reset, directed words, random words, then drain and finish
   initial begin
      cand_type directed[$];
      int       i;
      req_chan.valid     = 1'b0;
      req_chan.candidate = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed = '{
         32'sh8000_0000,  // most negative
         -1,
         0,
         1,
         2,               // the only even prime
         3,
         4,               // smallest even composite
         5,
         9,               // divisor squared equals the value
         25,
         49,
         121,
         63001,           // 251 squared
         65521,           // largest prime below 2^16
         65535,
         32'sh5555_5555,
         32'sh2aaa_aaaa,
         32'shaaaa_aaaa,
         2147483645,      // odd, divisible by 5
         2147483646,      // largest even value
         2147483647       // largest value, prime: longest run
      };
      foreach (directed[k]) send_word(directed[k], pick_gap());

      // pause the sender until the block has answered everything
      @(negedge clock);
      req_chan.valid = 1'b0;
      wait_for_drain();

      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 2) begin
            @(negedge clock);
            req_chan.valid = 1'b0;
            wait_for_drain();
         end
         send_word(random_candidate(), pick_gap());
      end
      @(negedge clock);
      req_chan.valid = 1'b0;

      // drain, then give the block time to show any stray flag word
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      foreach (board.verdicts[k])
         board.report_mismatch($sformatf("no flag for candidate %0d",
                                         board.verdicts[k].candidate));
      if (board.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Receiver: random hold-offs, plus one long stretch that backs the block up
   initial begin
      bit held_long;
      int gap;
      held_long      = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_long && flags_taken >= HOLD_AT_FLAG) begin
            held_long = 1'b1;
            gap       = LONG_HOLD;
         end else begin
            gap = pick_gap();
         end
         if (gap > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Monitor: check every accepted flag word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         board.check_flag(rsp_chan.prime_flag);
         flags_taken++;
      end
   end

   // Watchdog: several times the slowest correct run
   initial begin
      #60000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_if.sv
rtl/core/tdpt_datapath.sv
rtl/core/tdpt_ctrl.sv
rtl/core/trial_division_prime_test_top.sv
verif/trial_division_prime_test_top_tb.sv
